/* hdl/rfft_pkg.sv */
package rfft_pkg;

  // Default parameter values.
  localparam int MAX_POINTS_DEF   = 64;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int TWIDDLE_BITS_DEF = 16;

  // Fixed widths of the work store and of command address fields.
  localparam int WORK_W  = 23;
  localparam int AW_MAX  = 6;
  localparam int TWID_W  = 5;
  localparam int ROM_W   = 25;

  // Datapath operation codes.
  typedef logic [3:0] op_t;
  localparam op_t OP_IDLE    = 4'd0;
  localparam op_t OP_COPY_RD = 4'd1;
  localparam op_t OP_COPY_WR = 4'd2;
  localparam op_t OP_BF_RD   = 4'd3;
  localparam op_t OP_BF_MUL  = 4'd4;
  localparam op_t OP_BF_ADD  = 4'd5;
  localparam op_t OP_WR_A    = 4'd6;
  localparam op_t OP_WR_B    = 4'd7;
  localparam op_t OP_OUT_RD  = 4'd8;
  localparam op_t OP_OUT_LD  = 4'd9;

  // Command word from the controller to the datapath.
  typedef struct packed {
    op_t               op;
    logic [AW_MAX-1:0] addr_a;
    logic [AW_MAX-1:0] addr_b;
    logic [TWID_W-1:0] twid;
    logic              trivial;
    logic              zero_fill;
    logic              smp_we;
    logic [AW_MAX-1:0] smp_addr;
  } cmd_t;

  // cos(pi*i/32) for i = 0..16 in Q.30.
  localparam logic [30:0] COS_Q30 [17] = '{
    31'd1073741824, 31'd1068571464, 31'd1053110176, 31'd1027506862,
    31'd992008094,  31'd946955747,  31'd892783698,  31'd830013654,
    31'd759250125,  31'd681174602,  31'd596538995,  31'd506158392,
    31'd410903207,  31'd311690799,  31'd209476638,  31'd105245103,
    31'd0
  };

  // Quarter-wave ROM entry rounded half up to tw-1 fraction bits.
  function automatic logic [ROM_W-1:0] rom_entry(input logic [TWID_W-1:0] k,
                                                 input int tw);
    logic [31:0] s;
    s = {1'b0, COS_Q30[k]} + (32'd1 << (30 - tw));
    return ROM_W'(s >> (31 - tw));
  endfunction

endpackage

/* hdl/rfft_if.sv */
interface rfft_in_if #(
  parameter int SAMPLE_BITS = rfft_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rfft_out_if;
  logic                         valid;
  logic                         ready;
  logic [rfft_pkg::WORK_W-1:0]  bin_real;
  logic [rfft_pkg::WORK_W-1:0]  bin_imag;
  logic                         last_bin;
  logic                         truncated;

  modport source (output valid, output bin_real, output bin_imag, output last_bin,
                  output truncated, input ready);
  modport sink   (input valid, input bin_real, input bin_imag, input last_bin,
                  input truncated, output ready);
endinterface

/* hdl/rfft_dp.sv */
module rfft_dp #(
  parameter int MAX_POINTS   = rfft_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS  = rfft_pkg::SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS = rfft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                          clk,
  input  rfft_pkg::cmd_t                cmd,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  output logic [rfft_pkg::WORK_W-1:0]   bin_real,
  output logic [rfft_pkg::WORK_W-1:0]   bin_imag
);

  localparam int WORK_W = rfft_pkg::WORK_W;
  localparam int TWID_W = rfft_pkg::TWID_W;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int WW     = TWIDDLE_BITS + 1;
  localparam int PW     = WORK_W + WW;
  localparam int TW_W   = PW + 1 - (TWIDDLE_BITS - 1);
  localparam int SUM_W  = TW_W + 1;
  localparam logic signed [SUM_W-1:0] WMAX = SUM_W'((1 << (WORK_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] WMIN = SUM_W'(-(1 << (WORK_W - 1)));
  localparam logic signed [PW:0] HALF_LSB = (PW + 1)'(1 << (TWIDDLE_BITS - 2));

  function automatic logic [WORK_W-1:0] sat_w(input logic signed [SUM_W-1:0] x);
    if (x > WMAX) return WMAX[WORK_W-1:0];
    if (x < WMIN) return WMIN[WORK_W-1:0];
    return x[WORK_W-1:0];
  endfunction

  // Sample store and work store (real and imaginary packed together).
  logic [SAMPLE_BITS-1:0] smp_mem [DEPTH];
  logic [2*WORK_W-1:0]    wk_mem  [DEPTH];

  logic [SAMPLE_BITS-1:0] smp_rd_r;
  logic [2*WORK_W-1:0]    rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]      addr_a, addr_b;

  assign addr_a = cmd.addr_a[ADDR_W-1:0];
  assign addr_b = cmd.addr_b[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.smp_we) begin
      smp_mem[cmd.smp_addr[ADDR_W-1:0]] <= in_sample;
    end
    smp_rd_r <= smp_mem[addr_a];
  end

  // Twiddle from the quarter-wave ROM by quadrant symmetry.
  logic [TWID_W-1:0]          ti;
  logic [rfft_pkg::ROM_W-1:0] rom_r, rom_i;
  logic signed [WW-1:0]       wr, wi;

  always_comb begin
    ti = cmd.twid;
    if (ti <= TWID_W'(16)) begin
      rom_r = rfft_pkg::rom_entry(ti, TWIDDLE_BITS);
      rom_i = rfft_pkg::rom_entry(TWID_W'(16) - ti, TWIDDLE_BITS);
      wr    = signed'({1'b0, rom_r[TWIDDLE_BITS-1:0]});
    end else begin
      rom_r = rfft_pkg::rom_entry(TWID_W'(6'd32 - {1'b0, ti}), TWIDDLE_BITS);
      rom_i = rfft_pkg::rom_entry(ti - TWID_W'(16), TWIDDLE_BITS);
      wr    = -signed'({1'b0, rom_r[TWIDDLE_BITS-1:0]});
    end
    wi = signed'({1'b0, rom_i[TWIDDLE_BITS-1:0]});
  end

  // Butterfly pipeline: products, then rounding and add/subtract.
  logic signed [WORK_W-1:0] br, bi, ar, ai;
  logic signed [PW-1:0]     p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [2*WORK_W-1:0]      a_r, b_r;
  logic                     triv_r;
  logic signed [PW:0]       sum_re, sum_im;
  logic signed [TW_W-1:0]   tr, tim;
  logic [2*WORK_W-1:0]      res_a_r, res_b_r;

  assign br = signed'(rd_b_r[2*WORK_W-1:WORK_W]);
  assign bi = signed'(rd_b_r[WORK_W-1:0]);

  always_ff @(posedge clk) begin
    rd_a_r <= wk_mem[addr_a];
    rd_b_r <= wk_mem[addr_b];
    if (cmd.op == rfft_pkg::OP_BF_MUL) begin
      p_rr_r <= wr * br;
      p_ii_r <= wi * bi;
      p_ri_r <= wr * bi;
      p_ir_r <= wi * br;
      a_r    <= rd_a_r;
      b_r    <= rd_b_r;
      triv_r <= cmd.trivial;
    end
  end

  always_comb begin
    sum_re = (PW + 1)'(p_rr_r) - (PW + 1)'(p_ii_r) + HALF_LSB;
    sum_im = (PW + 1)'(p_ri_r) + (PW + 1)'(p_ir_r) + HALF_LSB;
    ar     = signed'(a_r[2*WORK_W-1:WORK_W]);
    ai     = signed'(a_r[WORK_W-1:0]);
    if (triv_r) begin
      tr  = TW_W'(signed'(b_r[2*WORK_W-1:WORK_W]));
      tim = TW_W'(signed'(b_r[WORK_W-1:0]));
    end else begin
      tr  = TW_W'(sum_re >>> (TWIDDLE_BITS - 1));
      tim = TW_W'(sum_im >>> (TWIDDLE_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rfft_pkg::OP_BF_ADD) begin
      res_a_r <= {sat_w(SUM_W'(ar) + SUM_W'(tr)), sat_w(SUM_W'(ai) + SUM_W'(tim))};
      res_b_r <= {sat_w(SUM_W'(ar) - SUM_W'(tr)), sat_w(SUM_W'(ai) - SUM_W'(tim))};
    end
  end

  // Single write port into the work store.
  logic                wk_we;
  logic [ADDR_W-1:0]   wk_addr;
  logic [2*WORK_W-1:0] wk_data;

  always_comb begin
    wk_we   = 1'b0;
    wk_addr = addr_a;
    wk_data = res_a_r;
    case (cmd.op)
      rfft_pkg::OP_COPY_WR: begin
        wk_we   = 1'b1;
        wk_data = cmd.zero_fill ? '0 :
                  {sat_w(SUM_W'(signed'(smp_rd_r))), {WORK_W{1'b0}}};
      end
      rfft_pkg::OP_WR_A: begin
        wk_we = 1'b1;
      end
      rfft_pkg::OP_WR_B: begin
        wk_we   = 1'b1;
        wk_addr = addr_b;
        wk_data = res_b_r;
      end
      default: begin
        wk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_mem[wk_addr] <= wk_data;
    end
  end

  // Output holding register.
  logic [WORK_W-1:0] out_re_r, out_im_r;

  always_ff @(posedge clk) begin
    if (cmd.op == rfft_pkg::OP_OUT_LD) begin
      out_re_r <= rd_a_r[2*WORK_W-1:WORK_W];
      out_im_r <= rd_a_r[WORK_W-1:0];
    end
  end

  assign bin_real = out_re_r;
  assign bin_imag = out_im_r;

endmodule

/* hdl/rfft_ctrl.sv */
module rfft_ctrl #(
  parameter int MAX_POINTS = rfft_pkg::MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_last_bin,
  output logic           out_truncated,
  output rfft_pkg::cmd_t cmd
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int LG_W   = $clog2(ADDR_W + 1);
  localparam int AW_MAX = rfft_pkg::AW_MAX;
  localparam int TWID_W = rfft_pkg::TWID_W;

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_CP_RD   = 4'd1;
  localparam logic [3:0] S_CP_WR   = 4'd2;
  localparam logic [3:0] S_BF_RD   = 4'd3;
  localparam logic [3:0] S_BF_MUL  = 4'd4;
  localparam logic [3:0] S_BF_ADD  = 4'd5;
  localparam logic [3:0] S_BF_WA   = 4'd6;
  localparam logic [3:0] S_BF_WB   = 4'd7;
  localparam logic [3:0] S_OUT_RD  = 4'd8;
  localparam logic [3:0] S_OUT_LD  = 4'd9;
  localparam logic [3:0] S_OUT_HLD = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic [LG_W-1:0]   stg_r, stg_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] bfly_r, bfly_nxt;
  logic              last_bin_r, last_bin_nxt;

  // Derived addresses and counts.
  logic [ADDR_W-1:0] size_m1, half_m1, hmask, rev, addr_a, addr_b, jj;
  logic [CNT_W-1:0]  cnt_inc;
  logic [LG_W-1:0]   lg_calc;
  logic              in_acc, full;

  always_comb begin
    size_m1 = ADDR_W'((1 << lg_r) - 1);
    half_m1 = (lg_r == '0) ? '0 : ADDR_W'((1 << (lg_r - 1)) - 1);
    hmask   = (stg_r == '0) ? '0 : ADDR_W'((1 << (stg_r - 1)) - 1);
    for (int b = 0; b < ADDR_W; b++) begin
      rev[b] = idx_r[ADDR_W-1-b];
    end
    rev     = rev >> (ADDR_W - lg_r);
    jj      = bfly_r & hmask;
    addr_a  = ((bfly_r & ~hmask) << 1) | jj;
    addr_b  = addr_a | (hmask + ADDR_W'(1));
  end

  assign in_acc = in_valid && in_ready;
  assign full   = (cnt_r >= CNT_W'(MAX_POINTS));

  always_comb begin
    cnt_inc = full ? cnt_r : cnt_r + CNT_W'(1);
    lg_calc = LG_W'(ADDR_W);
    for (int l = ADDR_W; l >= 0; l--) begin
      if ((1 << l) >= int'(cnt_inc)) lg_calc = LG_W'(l);
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    lg_nxt       = lg_r;
    stg_nxt      = stg_r;
    idx_nxt      = idx_r;
    bfly_nxt     = bfly_r;
    last_bin_nxt = last_bin_r;
    cmd          = '0;
    cmd.op       = rfft_pkg::OP_IDLE;
    cmd.smp_addr = AW_MAX'(cnt_r);
    cmd.addr_a   = AW_MAX'(addr_a);
    cmd.addr_b   = AW_MAX'(addr_b);
    cmd.twid     = TWID_W'(32'(jj) << (6 - int'(stg_r)));
    cmd.trivial  = (jj == '0);
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cmd.smp_we = !full;
          cnt_nxt    = cnt_inc;
          ovf_nxt    = ovf_r | full;
          if (in_last) begin
            lg_nxt    = lg_calc;
            idx_nxt   = '0;
            state_nxt = S_CP_RD;
          end
        end
      end
      S_CP_RD: begin
        cmd.op     = rfft_pkg::OP_COPY_RD;
        cmd.addr_a = AW_MAX'(rev);
        state_nxt  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.op        = rfft_pkg::OP_COPY_WR;
        cmd.addr_a    = AW_MAX'(idx_r);
        cmd.zero_fill = (CNT_W'(rev) >= cnt_r);
        if (idx_r == size_m1) begin
          idx_nxt   = '0;
          stg_nxt   = LG_W'(1);
          bfly_nxt  = '0;
          state_nxt = (lg_r == '0) ? S_OUT_RD : S_BF_RD;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_CP_RD;
        end
      end
      S_BF_RD: begin
        cmd.op    = rfft_pkg::OP_BF_RD;
        state_nxt = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd.op    = rfft_pkg::OP_BF_MUL;
        state_nxt = S_BF_ADD;
      end
      S_BF_ADD: begin
        cmd.op    = rfft_pkg::OP_BF_ADD;
        state_nxt = S_BF_WA;
      end
      S_BF_WA: begin
        cmd.op    = rfft_pkg::OP_WR_A;
        state_nxt = S_BF_WB;
      end
      S_BF_WB: begin
        cmd.op    = rfft_pkg::OP_WR_B;
        state_nxt = S_BF_RD;
        if (bfly_r == half_m1) begin
          bfly_nxt = '0;
          if (stg_r == lg_r) begin
            state_nxt = S_OUT_RD;
          end else begin
            stg_nxt = stg_r + LG_W'(1);
          end
        end else begin
          bfly_nxt = bfly_r + ADDR_W'(1);
        end
      end
      S_OUT_RD: begin
        cmd.op     = rfft_pkg::OP_OUT_RD;
        cmd.addr_a = AW_MAX'(idx_r);
        state_nxt  = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.op       = rfft_pkg::OP_OUT_LD;
        cmd.addr_a   = AW_MAX'(idx_r);
        last_bin_nxt = (idx_r == size_m1);
        state_nxt    = S_OUT_HLD;
      end
      S_OUT_HLD: begin
        if (out_ready) begin
          if (last_bin_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lg_r       <= lg_nxt;
    stg_r      <= stg_nxt;
    idx_r      <= idx_nxt;
    bfly_r     <= bfly_nxt;
    last_bin_r <= last_bin_nxt;
  end

  assign in_ready      = (state_r == S_LOAD);
  assign out_valid     = (state_r == S_OUT_HLD);
  assign out_last_bin  = last_bin_r;
  assign out_truncated = ovf_r;

  // The sample count never exceeds the frame capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("sample count beyond capacity");

  // The input and result sides are never open together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");

  // A final sample closes the input side on the next cycle.
  a_last_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last sample");

  // Butterfly stages stay within the transform size.
  a_stage: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BF_RD |-> stg_r <= lg_r && stg_r != '0)
    else $error("butterfly stage out of range");

endmodule

/* hdl/radix2_fft_frame.sv */
// Channel   Direction  Payload                                   Transaction
// in_chan   sink       sample, last                              valid && ready
// out_chan  source     bin_real, bin_imag, last_bin, truncated   valid && ready
//
// Samples load one per cycle until a transaction with last set.
// The transform then does the bit-reversed copy (a read and a write per point)
// and N/2*log2 N butterflies (read, multiply, add, write A, write B) through one
// shared unit and one write port, then outputs each bin, held until taken.
// Reset (rst_n low, synchronous) clears the sample count and drop flag.
// in_chan.ready stays low from the last sample until the last bin is taken.
module radix2_fft_frame #(
  parameter int MAX_POINTS   = rfft_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS  = rfft_pkg::SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS = rfft_pkg::TWIDDLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rfft_in_if.sink    in_chan,
  rfft_out_if.source out_chan
);

  rfft_pkg::cmd_t cmd;

  // Sequencer for load, copy, butterfly and output phases.
  rfft_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_last       (in_chan.last),
    .in_ready      (in_chan.ready),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_last_bin  (out_chan.last_bin),
    .out_truncated (out_chan.truncated),
    .cmd           (cmd)
  );

  // Stores, twiddle ROM and butterfly arithmetic.
  rfft_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_sample (in_chan.sample),
    .bin_real  (out_chan.bin_real),
    .bin_imag  (out_chan.bin_imag)
  );

endmodule
